### rtl/core/ccdphs_pkg.sv
// ----------------------------------------------------------------------------
// ccdphs_pkg
// shared types and constants of the ccd pulse height pipeline
// ----------------------------------------------------------------------------
package ccdphs_pkg;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_GAIN  = 2'd0,
    CFG_NOISE = 2'd1,
    CFG_FANO  = 2'd2
  } cfg_idx_e;

  localparam int unsigned D1_STEPS = 58;  // quotient bits of fano*e*2^26 / gain
  localparam int unsigned SQ_STEPS = 30;  // root bits of the 60-bit variance
  localparam int unsigned D2_STEPS = 34;  // quotient bits of (E' >> 28) / gain

  localparam logic [15:0] GAIN_RST  = 16'd3738;
  localparam logic [15:0] NOISE_RST = 16'd1024;
  localparam logic [15:0] FANO_RST  = 16'd7864;

  // per-item fields that ride along the pipeline
  typedef struct packed {
    logic [15:0] e;
    logic        gneg;
    logic [15:0] u;
    logic [31:0] gg;     // gain * |gauss|
  } pl_t;

  typedef struct packed {
    logic        sat;
    logic [30:0] recon;
    logic [14:0] pha;
  } res_t;

endpackage

### rtl/core/ccd_pulse_height_sim_top.sv
// ----------------------------------------------------------------------------
// ccd_pulse_height_sim_top
// pipelined ccd pulse height and dithered energy, when not stalled at one photon per cycle
// ----------------------------------------------------------------------------
// channel   dir  handshake                  content
// s_axis    in   tvalid/tready              photon energy, gauss and uniform deviates
// m_axis    out  tvalid/tready              pulse height, energy, saturation flag
// cfg       in   cfg_we_i (no wait)         gain, read noise, fano registers
//
// one item enters per cycle while the skid stage is empty; the bit-serial stages are
// 58 steps of the variance divider, 30 of the square root and 34 of the
// pulse height divider, plus six arithmetic stages and the output register.
// reset clears all valid bits and loads the register defaults.
// when the output stalls the pipeline keeps moving, closing bubbles, until an
// item lands in the skid stage; it then holds until the skid drains.
// ----------------------------------------------------------------------------
module ccd_pulse_height_sim_top
  import ccdphs_pkg::*;
#(
  parameter int unsigned PHA_MAX = 32767
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] photon_energy, [31:16] gauss_sample, [47:32] uniform_sample
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] channel, [45:15] recon_energy, [46] saturated, [47] zero
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [33:0] PhaMaxQ = 34'(PHA_MAX);
  localparam logic [14:0] PhaMaxP = 15'(PHA_MAX);

  logic en;  // whole pipeline advances

  // configuration registers
  logic [15:0] gain_q, noise_q, fano_q;
  logic [31:0] nn_q;  // read noise squared, follows the register

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RST;
      noise_q <= NOISE_RST;
      fano_q  <= FANO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN:  gain_q  <= cfg_data_i;
        CFG_NOISE: noise_q <= cfg_data_i;
        CFG_FANO:  fano_q  <= cfg_data_i;
        default:   ;  // unknown index, write ignored
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    nn_q <= noise_q * noise_q;
  end

  // ---------------------------------------------------------------- stage 0
  // fano*e and gain*|gauss|
  logic        v0_q;
  pl_t         pl0_q;
  logic [31:0] fe_q;
  logic [16:0] gmag;

  assign gmag = s_axis_tdata[31] ? (17'h10000 - {1'b0, s_axis_tdata[31:16]})
                                 : {1'b0, s_axis_tdata[31:16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pl0_q.e    <= s_axis_tdata[15:0];
      pl0_q.gneg <= s_axis_tdata[31];
      pl0_q.u    <= s_axis_tdata[47:32];
      pl0_q.gg   <= gain_q * gmag[15:0];
      fe_q       <= fano_q * s_axis_tdata[15:0];
    end
  end

  // ------------------------------------------- variance divider, bit serial
  logic        d1v_q   [D1_STEPS];
  pl_t         d1pl_q  [D1_STEPS];
  logic [15:0] d1rem_q [D1_STEPS];
  logic [57:0] d1nq_q  [D1_STEPS];

  for (genvar k = 0; k < D1_STEPS; k++) begin : g_d1
    logic        v_in;
    pl_t         pl_in;
    logic [15:0] rem_in;
    logic [57:0] nq_in;
    logic [16:0] t, diff;
    logic        ge;
    if (k == 0) begin : g_first
      assign v_in   = v0_q;
      assign pl_in  = pl0_q;
      assign rem_in = '0;
      assign nq_in  = {fe_q, 26'd0};
    end else begin : g_next
      assign v_in   = d1v_q[k-1];
      assign pl_in  = d1pl_q[k-1];
      assign rem_in = d1rem_q[k-1];
      assign nq_in  = d1nq_q[k-1];
    end
    assign t    = {rem_in, nq_in[57]};
    assign diff = t - {1'b0, gain_q};
    assign ge   = t >= {1'b0, gain_q};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) d1v_q[k] <= 1'b0;
      else if (en) d1v_q[k] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        d1pl_q[k]  <= pl_in;
        d1rem_q[k] <= ge ? diff[15:0] : t[15:0];
        d1nq_q[k]  <= {nq_in[56:0], ge};
      end
    end
  end

  // ------------------------------------------------------- variance sum
  logic        vv_q;
  pl_t         vpl_q;
  logic [59:0] var_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vv_q <= 1'b0;
    else if (en) vv_q <= d1v_q[D1_STEPS-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      vpl_q <= d1pl_q[D1_STEPS-1];
      var_q <= {12'd0, nn_q, 16'd0} + {2'd0, d1nq_q[D1_STEPS-1]};
    end
  end

  // ------------------------------------------------- square root, 2 bits a step
  logic        sqv_q    [SQ_STEPS];
  pl_t         sqpl_q   [SQ_STEPS];
  logic [30:0] sqrem_q  [SQ_STEPS];
  logic [29:0] sqroot_q [SQ_STEPS];
  logic [59:0] sqx_q    [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic        v_in;
    pl_t         pl_in;
    logic [30:0] rem_in;
    logic [29:0] root_in;
    logic [59:0] x_in;
    logic [32:0] t, trial, diff;
    logic        ge;
    if (k == 0) begin : g_first
      assign v_in    = vv_q;
      assign pl_in   = vpl_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = var_q;
    end else begin : g_next
      assign v_in    = sqv_q[k-1];
      assign pl_in   = sqpl_q[k-1];
      assign rem_in  = sqrem_q[k-1];
      assign root_in = sqroot_q[k-1];
      assign x_in    = sqx_q[k-1];
    end
    assign t     = {rem_in, x_in[59:58]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = t - trial;
    assign ge    = t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sqv_q[k] <= 1'b0;
      else if (en) sqv_q[k] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sqpl_q[k]   <= pl_in;
        sqrem_q[k]  <= ge ? diff[30:0] : t[30:0];
        sqroot_q[k] <= {root_in[28:0], ge};
        sqx_q[k]    <= {x_in[57:0], 2'b00};
      end
    end
  end

  // ------------------------------------------------ deviation gain*|g|*sigma
  logic        mv_q;
  pl_t         mpl_q;
  logic [61:0] dev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mv_q <= 1'b0;
    else if (en) mv_q <= sqv_q[SQ_STEPS-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mpl_q <= sqpl_q[SQ_STEPS-1];
      dev_q <= sqpl_q[SQ_STEPS-1].gg * sqroot_q[SQ_STEPS-1];
    end
  end

  // ------------------------------------------- perturbed energy, clamp at zero
  logic        ev_q;
  pl_t         epl_q;
  logic [33:0] dq_q;
  logic [61:0] epos, ep;

  assign epos = {8'd0, mpl_q.e, 38'd0};

  always_comb begin
    if (mpl_q.gneg) ep = (dev_q > epos) ? '0 : epos - dev_q;
    else            ep = epos + dev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ev_q <= 1'b0;
    else if (en) ev_q <= mv_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      epl_q <= mpl_q;
      dq_q  <= ep[61:28];
    end
  end

  // ----------------------------------------- pulse height divider, bit serial
  logic        d2v_q   [D2_STEPS];
  pl_t         d2pl_q  [D2_STEPS];
  logic [15:0] d2rem_q [D2_STEPS];
  logic [33:0] d2nq_q  [D2_STEPS];

  for (genvar k = 0; k < D2_STEPS; k++) begin : g_d2
    logic        v_in;
    pl_t         pl_in;
    logic [15:0] rem_in;
    logic [33:0] nq_in;
    logic [16:0] t, diff;
    logic        ge;
    if (k == 0) begin : g_first
      assign v_in   = ev_q;
      assign pl_in  = epl_q;
      assign rem_in = '0;
      assign nq_in  = dq_q;
    end else begin : g_next
      assign v_in   = d2v_q[k-1];
      assign pl_in  = d2pl_q[k-1];
      assign rem_in = d2rem_q[k-1];
      assign nq_in  = d2nq_q[k-1];
    end
    assign t    = {rem_in, nq_in[33]};
    assign diff = t - {1'b0, gain_q};
    assign ge   = t >= {1'b0, gain_q};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) d2v_q[k] <= 1'b0;
      else if (en) d2v_q[k] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        d2pl_q[k]  <= pl_in;
        d2rem_q[k] <= ge ? diff[15:0] : t[15:0];
        d2nq_q[k]  <= {nq_in[32:0], ge};
      end
    end
  end

  // ------------------------------------------------ channel and saturation
  logic        pv_q, sat_q;
  logic [14:0] pha_q;
  logic [30:0] x_q;
  logic [33:0] q;
  logic        sat_d;
  logic [14:0] pha_d;

  assign q     = d2nq_q[D2_STEPS-1];
  assign sat_d = q >= PhaMaxQ;
  assign pha_d = sat_d ? PhaMaxP : q[14:0] + 15'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else if (en) pv_q <= d2v_q[D2_STEPS-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_q <= sat_d;
      pha_q <= pha_d;
      x_q   <= {pha_d, 16'd0} - {15'd0, d2pl_q[D2_STEPS-1].u};
    end
  end

  // ---------------------------------------- dithered energy, zero gain forcing
  // the product stays below 2^47 for any channel up to 32767, so no clip here
  logic        rv_q;
  res_t        rres_q;
  logic [46:0] prod;

  assign prod = x_q * gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else if (en) rv_q <= pv_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (gain_q == 16'd0) begin
        rres_q <= '0;
      end else begin
        rres_q.pha   <= pha_q;
        rres_q.recon <= prod[46:16];
        rres_q.sat   <= sat_q;
      end
    end
  end

  // ------------------------------------------- output register and skid stage
  logic ov_q, sv_q;
  res_t od_q, sd_q;

  assign en            = !sv_q;
  assign s_axis_tready = en;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, od_q.sat, od_q.recon, od_q.pha};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (ov_q && !m_axis_tready) begin
      if (en && rv_q) sv_q <= 1'b1;
    end else if (sv_q) begin
      ov_q <= 1'b1;
      sv_q <= 1'b0;
    end else begin
      ov_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ov_q && !m_axis_tready) begin
      if (en && rv_q) sd_q <= rres_q;
    end else if (sv_q) begin
      od_q <= sd_q;
    end else begin
      od_q <= rres_q;
    end
  end

  // ---------------------------------------------------------------- checks
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q) else $error("skid holds an item while output is empty");

  a_sat_clips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv_q && sat_q) |-> (pha_q == PhaMaxP)) else $error("saturated channel not clipped");

  a_pha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (pha_q <= PhaMaxP && pha_q != 15'd0)) else $error("channel out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($past(rv_q) == rv_q)) else $error("pipeline moved while stalled");

endmodule

### sim/tb_ccd_pulse_height_sim_top.sv
// ----------------------------------------------------------------------------
// tb_ccd_pulse_height_sim_top
// self-checking bench for the ccd pulse height pipeline
// ----------------------------------------------------------------------------
// photon items are streamed in with random gaps while the result side stalls
// at random. every accepted item is run through a bit-exact integer model of
// the noise, perturbation, pulse height and dither math, and the expected
// result is queued; each result leaving the block is compared field by field
// with the oldest entry. the registers are reloaded between phases while the
// pipeline is empty, walking through the defaults, the extremes and zero gain.
// ----------------------------------------------------------------------------
module tb_ccd_pulse_height_sim_top;
  import ccdphs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHA_LIMIT = 32767;
  localparam int unsigned N_PHASES  = 8;
  localparam int unsigned PHASE_RND = 170;  // random items per phase

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  // bench copy of the three registers
  logic [15:0] gain_q;
  logic [15:0] noise_q;
  logic [15:0] fano_q;

  logic [47:0] photon_q[$];   // items waiting to be sent
  res_t        pha_exp_q[$];  // predicted results, oldest first

  int unsigned gap_cnt;
  int unsigned stall_cnt;
  bit          idle_en;
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_sat     = 0;
  int unsigned n_err     = 0;

  ccd_pulse_height_sim_top #(.PHA_MAX(PHA_LIMIT)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // integer square root, floor, by trial of each root bit
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 30; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // channel, dithered energy and clip flag for one photon
  function automatic res_t predict_result(input logic [47:0] item);
    logic [63:0] e, u, g, gmag, var_q, sigma, dev, ep, q, pha, recon;
    logic        gneg;
    res_t        r;
    e    = {48'd0, item[15:0]};
    u    = {48'd0, item[47:32]};
    g    = {48'd0, gain_q};
    gneg = item[31];
    r    = '0;
    if (g == 0) return r;  // zero gain forces all-zero result
    var_q = (({48'd0, noise_q} * {48'd0, noise_q}) << 16)
          + ((({48'd0, fano_q} * e) << 26) / g);
    sigma = root_floor(var_q);
    gmag  = gneg ? (64'h10000 - {48'd0, item[31:16]}) : {48'd0, item[31:16]};
    dev   = g * sigma * gmag;
    ep    = e << 38;
    if (gneg) ep = (dev > ep) ? 64'd0 : ep - dev;  // clamp negative energy
    else ep = ep + dev;
    q = ep / (g << 28);
    if (q >= 64'(PHA_LIMIT)) begin
      pha   = 64'(PHA_LIMIT);
      r.sat = 1'b1;
    end else begin
      pha = q + 64'd1;
    end
    recon = (((pha << 16) - u) * g) >> 16;
    if (recon > 64'h7FFF_FFFF) begin
      recon = 64'h7FFF_FFFF;
      r.sat = 1'b1;
    end
    r.pha   = pha[14:0];
    r.recon = recon[30:0];
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (!idle_en || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: one item per handshake, gaps between items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap_cnt       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pha_exp_q.push_back(predict_result(s_axis_tdata));
        n_sent <= n_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_cnt != 0) begin
          gap_cnt       <= gap_cnt - 1;
          s_axis_tvalid <= 1'b0;
        end else if (photon_q.size() != 0) begin
          s_axis_tdata  <= photon_q.pop_front();
          s_axis_tvalid <= 1'b1;
          gap_cnt       <= gap_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure and field compare
  always @(posedge clk_i or negedge rst_ni) begin
    res_t        want;
    int unsigned errs;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt     <= 0;
    end else begin
      errs = 0;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pha_exp_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
          errs++;
        end else begin
          want = pha_exp_q.pop_front();
          n_checked <= n_checked + 1;
          if (want.sat) n_sat <= n_sat + 1;
          if (m_axis_tdata[14:0] !== want.pha) begin
            $display("%0t: channel exp %0d got %0d", $realtime, want.pha,
                     m_axis_tdata[14:0]);
            errs++;
          end
          if (m_axis_tdata[45:15] !== want.recon) begin
            $display("%0t: recon_energy exp %0d got %0d", $realtime, want.recon,
                     m_axis_tdata[45:15]);
            errs++;
          end
          if (m_axis_tdata[47:46] !== {1'b0, want.sat}) begin
            $display("%0t: saturated/pad exp %b got %b", $realtime,
                     {1'b0, want.sat}, m_axis_tdata[47:46]);
            errs++;
          end
        end
      end
      n_err <= n_err + errs;
      if (stall_cnt != 0) begin
        m_axis_tready <= 1'b0;
        stall_cnt     <= stall_cnt - 1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        stall_cnt     <= gap_len();
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_GAIN:  gain_q  = val;
      CFG_NOISE: noise_q = val;
      CFG_FANO:  fano_q  = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_photon(input logic [15:0] e, input logic [15:0] g,
                            input logic [15:0] u);
    photon_q.push_back({u, g, e});
  endtask

  // random photon, energies biased toward small and edge values
  task automatic add_random_photon();
    logic [15:0] e, g;
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 4) e = 16'($urandom_range(0, 65535));
    else if (p < 7) e = 16'($urandom_range(0, 2000));
    else if (p < 8) e = 16'($urandom_range(65000, 65535));
    else e = 16'($urandom_range(0, 15));
    p = $urandom_range(0, 19);
    if (p == 0) g = 16'h8000;
    else if (p == 1) g = 16'h7FFF;
    else g = 16'($urandom_range(0, 65535));
    add_photon(e, g, 16'($urandom_range(0, 65535)));
  endtask

  task automatic wait_drained();
    while (photon_q.size() != 0 || s_axis_tvalid || pha_exp_q.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] ph_gain  [N_PHASES];
    logic [15:0] ph_noise [N_PHASES];
    logic [15:0] ph_fano  [N_PHASES];
    // defaults, then the extremes, zero gain and mixed settings
    ph_gain  = '{GAIN_RST, 16'd1, 16'hFFFF, 16'd0, 16'd256, 16'd20000, 16'd3000,
                 GAIN_RST};
    ph_noise = '{NOISE_RST, 16'd0, 16'hFFFF, 16'd500, 16'd1024, 16'd0, 16'd40000,
                 NOISE_RST};
    ph_fano  = '{FANO_RST, 16'd0, 16'hFFFF, 16'd100, 16'hFFFF, 16'd30000, 16'd1,
                 FANO_RST};
    gain_q        = GAIN_RST;
    noise_q       = NOISE_RST;
    fano_q        = FANO_RST;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_GAIN;
    cfg_data_i    = '0;
    idle_en       = 1'b1;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) begin
        write_reg(CFG_GAIN, ph_gain[ph]);
        write_reg(CFG_NOISE, ph_noise[ph]);
        write_reg(CFG_FANO, ph_fano[ph]);
      end
      // every third phase runs without any idling
      idle_en = (ph % 3) != 2;
      if (ph == 0 || ph == 1 || ph == 3) begin
        // field extremes, clamp to zero, saturation, dither ends
        add_photon(16'd0, 16'd0, 16'd0);
        add_photon(16'hFFFF, 16'd0, 16'hFFFF);
        add_photon(16'hFFFF, 16'h7FFF, 16'd0);
        add_photon(16'hFFFF, 16'h8000, 16'hFFFF);
        add_photon(16'd0, 16'h8000, 16'd12345);
        add_photon(16'd5, 16'h8000, 16'd1);
        add_photon(16'd1, 16'hF000, 16'h8000);
        add_photon(16'd5900, 16'd0, 16'h0001);
        add_photon(16'd5900, 16'h1000, 16'hFFFE);
        add_photon(16'd5900, 16'hF000, 16'h7FFF);
      end
      for (int i = 0; i < PHASE_RND; i++) add_random_photon();
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    $display("covered %0d photons over %0d register settings, %0d clipped",
             n_checked, N_PHASES, n_sat);
    if (n_err == 0 && pha_exp_q.size() == 0) begin
      $display("ccd_pulse_height_sim_top regression: pass");
    end else begin
      $display("mismatches %0d, results still missing %0d", n_err, pha_exp_q.size());
      $display("ccd_pulse_height_sim_top regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pha_exp_q.size());
    $display("ccd_pulse_height_sim_top regression: fail");
    $finish;
  end

endmodule
